[sv/fbpa_pkg.sv]
package fbpa_pkg;

    // Payload alignment of every block.
    localparam int unsigned ALIGN_BYTES = 8;

    // Operation carried in the input tuser field.
    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2
    } kind_t;

    // Result code carried in the output tuser field.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    sweep_clr;
        logic    sweep_step;
        logic    init_commit;
        logic    link_rd;
        logic    alloc_commit;
        logic    rel_load;
        logic    mul_load;
        logic    q_load;
        logic    free_commit;
        logic    res_load;
        logic    res_addr_ok;
        status_t res_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_null;
        logic sweep_last;
        logic free_ok;
    } stat_t;

endpackage

[sv/fbpa_datapath.sv]
module fbpa_datapath #(
    parameter int NUM_BLOCKS   = 128,
    parameter int BLOCK_BYTES  = 64,
    parameter int HEADER_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  logic [31:0]        free_address,
    input  fbpa_pkg::cmd_t     cmd,
    output fbpa_pkg::stat_t    stat,
    output logic [31:0]        res_address,
    output fbpa_pkg::status_t  res_status
);
    import fbpa_pkg::*;

    // Geometry of the pool.
    localparam int PAYLOAD_ALIGNED =
        ((BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int STRIDE  = HEADER_BYTES + PAYLOAD_ALIGNED;
    localparam int LIMIT   = NUM_BLOCKS * STRIDE;
    localparam int IDX_W   = $clog2(NUM_BLOCKS + 1);
    localparam int AW      = $clog2(NUM_BLOCKS);
    localparam int STR_W   = $clog2(STRIDE + 1);
    localparam int REL_W   = $clog2(LIMIT);
    localparam int PA_W    = IDX_W + STR_W;
    localparam int P1_W    = 2 * REL_W;
    localparam int RECIP   = (1 << REL_W) / STRIDE;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    // Link memory: one write and one registered read per cycle.
    logic [IDX_W-1:0] link_mem [NUM_BLOCKS];
    logic [IDX_W-1:0] rd_data_reg;

    logic [31:0]      base_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] sweep_cnt_reg;
    logic [31:0]      rel_reg;
    logic [P1_W-1:0]  prod1_reg;
    logic             inrange_reg;
    logic [IDX_W-1:0] q_reg;
    logic [PA_W-1:0]  prod2_reg;
    logic [PA_W-1:0]  proda_reg;
    logic [31:0]      out_addr_reg;
    status_t          out_status_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic [REL_W-1:0] rem;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      alloc_addr;

    // Remainder check after the reciprocal estimate; one correction step.
    assign rem      = rel_reg[REL_W-1:0] - REL_W'(prod2_reg);
    assign free_idx = (rem == '0) ? q_reg : q_reg + IDX_W'(1);
    assign alloc_addr = base_reg + 32'(HEADER_BYTES) + 32'(proda_reg);

    assign stat.head_null  = (head_reg >= NULL_IDX);
    assign stat.sweep_last = (sweep_cnt_reg == LAST_IDX);
    assign stat.free_ok    = inrange_reg && ((rem == '0) || (rem == REL_W'(STRIDE)));

    assign res_address = out_addr_reg;
    assign res_status  = out_status_reg;

    // Link memory write source.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_cnt_reg[AW-1:0];
        wr_data = NULL_IDX;
        if (cmd.sweep_step)
        begin
            wr_en = 1'b1;
            if (sweep_cnt_reg != '0)
            begin
                wr_data = sweep_cnt_reg - IDX_W'(1);
            end
        end
        else if (cmd.alloc_commit)
        begin
            wr_en   = 1'b1;
            wr_addr = head_reg[AW-1:0];
        end
        else if (cmd.free_commit)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx[AW-1:0];
            wr_data = head_reg;
        end
    end

    // Head of the free list.
    always_comb
    begin
        head_next = head_reg;
        if (cmd.init_commit)
        begin
            head_next = LAST_IDX;
        end
        else if (cmd.alloc_commit)
        begin
            head_next = (rd_data_reg >= NULL_IDX) ? NULL_IDX : rd_data_reg;
        end
        else if (cmd.free_commit)
        begin
            head_next = free_idx;
        end
    end

    // Memory access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.link_rd)
        begin
            rd_data_reg <= link_mem[head_reg[AW-1:0]];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            head_reg      <= NULL_IDX;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            head_reg <= head_next;
            if (cmd.sweep_clr)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
            end
        end
    end

    // Address arithmetic and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.link_rd)
        begin
            proda_reg <= PA_W'(head_reg) * PA_W'(STRIDE);
        end
        if (cmd.rel_load)
        begin
            rel_reg <= free_address - base_reg - 32'(HEADER_BYTES);
        end
        if (cmd.mul_load)
        begin
            prod1_reg   <= P1_W'(rel_reg[REL_W-1:0]) * P1_W'(RECIP);
            inrange_reg <= (rel_reg < 32'(LIMIT));
        end
        if (cmd.q_load)
        begin
            q_reg     <= prod1_reg[REL_W +: IDX_W];
            prod2_reg <= PA_W'(prod1_reg[REL_W +: IDX_W]) * PA_W'(STRIDE);
        end
        if (cmd.res_load)
        begin
            out_addr_reg   <= cmd.res_addr_ok ? alloc_addr : 32'd0;
            out_status_reg <= cmd.res_status;
        end
    end

endmodule

[sv/fbpa_ctrl.sv]
module fbpa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      kind,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  fbpa_pkg::stat_t stat,
    output fbpa_pkg::cmd_t  cmd
);
    import fbpa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ALLOC_UPD,
        ST_FREE_MUL,
        ST_FREE_Q,
        ST_FREE_CHK,
        ST_RESP
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    m_tvalid_reg;
    logic    m_tvalid_next;
    status_t resp_status_reg;
    status_t resp_status_next;
    logic    resp_addr_ok_reg;
    logic    resp_addr_ok_next;

    logic    out_free;
    logic    done;
    status_t done_status;
    logic    done_addr_ok;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next        = state_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        resp_status_next  = resp_status_reg;
        resp_addr_ok_next = resp_addr_ok_reg;
        cmd               = '0;
        done              = 1'b0;
        done_status       = STATUS_OK;
        done_addr_ok      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (kind_t'(kind))
                        KIND_INIT:
                        begin
                            cmd.sweep_clr = 1'b1;
                            state_next    = ST_SWEEP;
                        end
                        KIND_ALLOC:
                        begin
                            if (stat.head_null)
                            begin
                                done        = 1'b1;
                                done_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.link_rd = 1'b1;
                                state_next  = ST_ALLOC_UPD;
                            end
                        end
                        KIND_FREE:
                        begin
                            cmd.rel_load = 1'b1;
                            state_next   = ST_FREE_MUL;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.init_commit = 1'b1;
                    done            = 1'b1;
                end
            end
            ST_ALLOC_UPD:
            begin
                cmd.alloc_commit = 1'b1;
                done             = 1'b1;
                done_addr_ok     = 1'b1;
            end
            ST_FREE_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_FREE_Q;
            end
            ST_FREE_Q:
            begin
                cmd.q_load = 1'b1;
                state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                done = 1'b1;
                if (stat.free_ok)
                begin
                    cmd.free_commit = 1'b1;
                end
                else
                begin
                    done_status = STATUS_BAD_ADDR;
                end
            end
            ST_RESP:
            begin
                done         = 1'b1;
                done_status  = resp_status_reg;
                done_addr_ok = resp_addr_ok_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result to the output register, or hold it until the slot frees.
        if (done)
        begin
            if (out_free)
            begin
                cmd.res_load    = 1'b1;
                cmd.res_status  = done_status;
                cmd.res_addr_ok = done_addr_ok;
                m_tvalid_next   = 1'b1;
                state_next      = ST_IDLE;
            end
            else
            begin
                resp_status_next  = done_status;
                resp_addr_ok_next = done_addr_ok;
                state_next        = ST_RESP;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            resp_status_reg  <= STATUS_OK;
            resp_addr_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            resp_status_reg  <= resp_status_next;
            resp_addr_ok_reg <= resp_addr_ok_next;
        end
    end

endmodule

[sv/fixed_block_pool_allocator_top.sv]
// Fixed-size block pool allocator with a LIFO free list of block indices.
// Input items arrive on s_tvalid/s_tready: s_tuser holds the operation
// (init, allocate, free) and s_tdata the payload address returned by a free.
// One result item per input item leaves on m_tvalid/m_tready: m_tdata holds
// the allocated payload address (zero otherwise), m_tuser the status code.
// The cfg_valid/cfg_ready channel writes the pool base address; write it
// only while no item is in flight.
// Items are handled one at a time. Allocate does a link memory read, then a
// head update; free does subtract, reciprocal multiply, back multiply and
// remainder check; init sweeps the link memory one entry a cycle.
// The next item is accepted in the cycle after the result is loaded.
// Reset empties the free list and clears the base address; the link memory
// is not cleared, so allocations find an empty list until an init or a free.
// A stalled receiver holds the result in the output register; the block
// keeps working on the next item and waits only when it has a new result.
module fixed_block_pool_allocator_top #(
    parameter int NUM_BLOCKS   = 128,
    parameter int BLOCK_BYTES  = 64,
    parameter int HEADER_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,    // base_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // free_address
    input  logic [1:0]  s_tuser,     // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // address
    output logic [1:0]  m_tuser      // status
);
    import fbpa_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    status_t res_status;

    assign cfg_ready = 1'b1;
    assign m_tuser   = res_status;

    fbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbpa_datapath #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .free_address (s_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .res_address  (m_tdata),
        .res_status   (res_status)
    );

    // An init item always keeps the block busy for the sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_INIT)) |=> !s_tready)
        else $error("input accepted during init sweep");

    // Only a successful allocate carries a nonzero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata == 32'd0))
        else $error("nonzero address with failing status");

    // Results carry only defined status codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == STATUS_OK) || (m_tuser == STATUS_EMPTY) ||
                      (m_tuser == STATUS_BAD_ADDR)))
        else $error("undefined status code");

endmodule

[tb/sv/fixed_block_pool_allocator_top_tb.sv]
`timescale 1ns / 1ps

module fixed_block_pool_allocator_top_tb;
    import fbpa_pkg::*;

    localparam int NUM_BLOCKS   = 128;
    localparam int BLOCK_BYTES  = 64;
    localparam int HEADER_BYTES = 8;
    localparam int unsigned STRIDE_BYTES = HEADER_BYTES
        + ((BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int unsigned NULL_BLOCK = NUM_BLOCKS;
    // The operation code that the block has no use for.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 270;

    typedef struct {
        logic [31:0] address;
        status_t     status;
    } alloc_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // free_address
    logic [1:0]  s_tuser   = '0;   // kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // address
    logic [1:0]  m_tuser;          // status

    // Shadow of the allocator: base register, free-list top and links.
    logic [31:0]   pool_base = '0;
    int unsigned   free_top  = NULL_BLOCK;
    int unsigned   block_below [NUM_BLOCKS];

    alloc_result_t expected_results [$];
    logic [31:0]   held_payloads [$];
    int            errors         = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    int            sink_hold_req  = 0;

    fixed_block_pool_allocator_top #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Payload address of a block under the current base, wrapping at 32 bits.
    function automatic logic [31:0] payload_at(int unsigned idx);
        return pool_base + HEADER_BYTES + STRIDE_BYTES * idx;
    endfunction

    // Applies one operation to the shadow free list and returns its answer.
    function automatic alloc_result_t predict_pool_op(logic [1:0] kind, logic [31:0] addr);
        alloc_result_t res;
        logic [31:0]   rel;
        int unsigned   idx;
        int            i;
        res.address = '0;
        res.status  = STATUS_OK;
        case (kind)
            KIND_INIT:
            begin
                // Every block links to the one below it; the last is on top.
                for (i = 0; i < NUM_BLOCKS; i++)
                    block_below[i] = (i == 0) ? NULL_BLOCK : i - 1;
                free_top = NUM_BLOCKS - 1;
            end
            KIND_ALLOC:
            begin
                if (free_top >= NULL_BLOCK)
                    res.status = STATUS_EMPTY;
                else
                begin
                    idx = free_top;
                    free_top = (block_below[idx] >= NULL_BLOCK) ? NULL_BLOCK : block_below[idx];
                    block_below[idx] = NULL_BLOCK;
                    res.address = payload_at(idx);
                end
            end
            KIND_FREE:
            begin
                // Map the payload address back to a block; refuse it if off-grid.
                rel = addr - pool_base - HEADER_BYTES;
                idx = rel / STRIDE_BYTES;
                if ((rel % STRIDE_BYTES) != 0 || idx >= NUM_BLOCKS)
                    res.status = STATUS_BAD_ADDR;
                else
                begin
                    block_below[idx] = free_top;
                    free_top = idx;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Offers one item, waits until it is taken, then records its answer.
    task automatic send_item(logic [1:0] kind, logic [31:0] addr);
        alloc_result_t res;
        int            i;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= addr;
        do @(posedge clk); while (!s_tready);
        res = predict_pool_op(kind, addr);
        expected_results.push_back(res);
        // Keep track of blocks handed out so that frees can return them.
        if (kind == KIND_INIT)
            held_payloads.delete();
        else if (kind == KIND_ALLOC && res.status == STATUS_OK)
            held_payloads.push_back(res.address);
        else if (kind == KIND_FREE && res.status == STATUS_OK)
        begin
            for (i = 0; i < held_payloads.size(); i++)
            begin
                if (held_payloads[i] == addr)
                begin
                    held_payloads.delete(i);
                    break;
                end
            end
        end
    endtask

    // Stops offering items and waits until every answer has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Writes the base register while the block is idle.
    task automatic write_base(logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_base = value;
        held_payloads.delete();
    endtask

    // Mostly well-formed allocate/free traffic, with some stray frees and the odd init mixed in.
    task automatic send_random_op(int alloc_pct);
        int          pick;
        int unsigned idx;
        logic [31:0] addr;
        pick = $urandom_range(99);
        if (pick < 1)
            send_item(KIND_INIT, $urandom());
        else if (pick < 4)
            send_item(KIND_FREE, $urandom());
        else if (pick < 7)
        begin
            // Near a block start, including one block past the end.
            idx  = $urandom_range(NUM_BLOCKS);
            addr = payload_at(idx) + $urandom_range(6) - 3;
            send_item(KIND_FREE, addr);
        end
        else if (pick < 9)
            send_item(KIND_FREE, payload_at($urandom_range(NUM_BLOCKS - 1)));
        else if (held_payloads.size() == 0 || $urandom_range(99) < alloc_pct)
            send_item(KIND_ALLOC, $urandom());
        else
        begin
            idx = $urandom_range(held_payloads.size() - 1);
            send_item(KIND_FREE, held_payloads[idx]);
        end
    endtask

    // Operations on the empty list that reset leaves behind.
    task automatic test_before_init();
        send_item(KIND_ALLOC, $urandom());
        send_item(KIND_FREE, payload_at(5));
        send_item(KIND_ALLOC, '0);
        send_item(KIND_ALLOC, '1);
        send_item(KIND_UNUSED, $urandom());
        send_item(KIND_FREE, '0);
    endtask

    // Address checks with a base that makes the pool wrap past zero.
    task automatic test_address_edges();
        write_base(32'hFFFF_FFF0);
        send_item(KIND_INIT, '1);
        send_item(KIND_ALLOC, '0);
        send_item(KIND_ALLOC, '0);
        // Block zero is still on the list, so this free is a double free.
        send_item(KIND_FREE, payload_at(0));
        send_item(KIND_ALLOC, '0);
        send_item(KIND_FREE, pool_base);
        send_item(KIND_FREE, payload_at(3) + 1);
        send_item(KIND_FREE, payload_at(3) - 1);
        send_item(KIND_FREE, payload_at(NUM_BLOCKS));
        send_item(KIND_FREE, payload_at(NUM_BLOCKS - 1));
        send_item(KIND_FREE, '0);
        send_item(KIND_FREE, '1);
        send_item(KIND_ALLOC, '0);
    endtask

    // The receiver holds off for a long time while items keep coming.
    task automatic test_backpressure();
        int n;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(KIND_INIT, '0);
        sink_hold_req = 300;
        for (n = 0; n < 30; n++)
        begin
            if (n % 3 == 2 && held_payloads.size() != 0)
                send_item(KIND_FREE, held_payloads[0]);
            else
                send_item(KIND_ALLOC, $urandom());
        end
        wait_drained();
    endtask

    // Random traffic under each idling pattern and a new base each time.
    task automatic test_random_phases();
        int          src_pcts [4];
        int          sink_pcts [4];
        logic [31:0] bases [4];
        int          p;
        int          n;
        int          alloc_pct;
        src_pcts  = '{0, 59, 0, 17};
        sink_pcts = '{0, 0, 59, 17};
        bases[0]  = 32'hFFFF_FFFF;
        bases[1]  = $urandom();
        bases[2]  = 32'h0000_0000;
        bases[3]  = $urandom();
        for (p = 0; p < 4; p++)
        begin
            write_base(bases[p]);
            src_idle_pct   = src_pcts[p];
            sink_stall_pct = sink_pcts[p];
            send_item(KIND_INIT, $urandom());
            // Drain the pool dry first, then wander with a changing mix.
            alloc_pct = 100;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n >= 150 && (n - 150) % 40 == 0)
                    alloc_pct = $urandom_range(10, 90);
                send_random_op(alloc_pct);
            end
        end
    endtask

    // Receiver: random stalls, or a long hold when one is requested.
    initial
    begin : sink_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req > 0)
            begin
                hold_left = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expected answer.
    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: address %h status %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== want.address)
                begin
                    $display("%0t: address mismatch: expected %h actual %h",
                             $time, want.address, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("fixed_block_pool_allocator_top test failed");
        $finish;
    end

    initial
    begin : run_tests
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_before_init();
        test_address_edges();
        test_backpressure();
        test_random_phases();
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("fixed_block_pool_allocator_top test passed");
        else
            $display("fixed_block_pool_allocator_top test failed");
        $finish;
    end

endmodule
